>>> hdl/rrt_pkg.sv
`default_nettype none
package rrt_pkg;

	localparam int MAX_OUT = 15;
	localparam int NW = 4;

	localparam logic [1:0] OP_SEG  = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_ACK  = 2'd2;

	typedef struct packed {
		logic [31:0] s;
		logic [31:0] e;
	} range_t;

	typedef struct packed {
		logic        accepted;
		logic        would_block;
		logic        list_full;
		logic [21:0] buffer_pos;
		logic [11:0] data_offset;
		logic [22:0] byte_count;
		logic [31:0] contiguous_end;
		logic [31:0] gap_start;
		logic [31:0] gap_end;
		logic        gap_valid;
		logic        last;
	} res_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_CHECK  = 8'b0000_0010,
		ST_READ   = 8'b0000_0100,
		ST_MERGE  = 8'b0000_1000,
		ST_MFIN   = 8'b0001_0000,
		ST_EMIT   = 8'b0010_0000,
		ST_ACK_RD = 8'b0100_0000,
		ST_ACK_EM = 8'b1000_0000
	} state_t;

	// serial number compare: a is before b
	function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

endpackage
`default_nettype wire

>>> hdl/reassembly_range_tracker.sv
// Reassembly range tracker: keeps the received byte ranges of a stream and
// answers segment, read and ack requests one item at a time.
// Request channel (req_valid/req_stall): opcode, seq_start, seg_len,
// request_len. req_stall is high while an item is in work.
// Result channel (res_valid/res_stall): one result per segment, read or
// unused opcode; an ack gives one result per gap (at most 15), or a single
// result when there is no gap, and last marks the final one. A held result
// stays stable while res_stall is high, and the block waits before loading
// the next result.
// Steps per item: a read goes CHECK, READ, EMIT; a segment goes CHECK, then
// EMIT if rejected, else MERGE and MFIN before EMIT; the merge walk takes
// one list element per cycle. An ack reads each gap's range in ACK_RD with
// the registered read of the range memory and gives it in ACK_EM. A result
// is valid in the same cycle as the block can take the next item.
// The head range sits in flip-flops; the other ranges live in a two-bank
// memory, the merge writes the other bank and flips only on success, so a
// full list leaves the old contents in place.
// Reset puts the head range at zero to zero with one range in the list; no
// clearing pass is needed.
`default_nettype none
module reassembly_range_tracker
	import rrt_pkg::*;
#(
	parameter int BUFFER_BYTES = 4194304,
	parameter int MAX_RANGES   = 16,
	parameter int MAX_SEG_LEN  = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] seq_start,
	input  wire logic [11:0] seg_len,
	input  wire logic [22:0] request_len,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             accepted,
	output logic             would_block,
	output logic             list_full,
	output logic [21:0]      buffer_pos,
	output logic [11:0]      data_offset,
	output logic [22:0]      byte_count,
	output logic [31:0]      contiguous_end,
	output logic [31:0]      gap_start,
	output logic [31:0]      gap_end,
	output logic             gap_valid,
	output logic             last
);

	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int MA = $clog2(2 * MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int MW = $clog2(MAX_RANGES + 2);
	localparam logic [31:0] BUF_MASK = 32'(BUFFER_BYTES - 1);
	localparam logic [31:0] BUF_SIZE = 32'(BUFFER_BYTES);

	state_t state_q;

	logic [1:0]  op_q;
	logic [31:0] seq_q;
	logic [11:0] len_q;
	logic [22:0] rlen_q;

	range_t      head_q;
	range_t      nh_q;
	range_t      acc_q;
	logic [CW-1:0] count_q;
	logic        bank_q;
	logic [CW-1:0] idx_q;
	logic [MW-1:0] m_q;
	logic        ins_q;
	logic [31:0] start_q;
	logic [31:0] send_q;
	logic [31:0] diff_q;
	logic [31:0] prev_e_q;
	logic [NW-1:0] n_q;

	res_t        res_q;
	res_t        out_q;
	logic        out_valid_q;

	range_t      mem [2 * MAX_RANGES];
	range_t      rd_q;

	// memory port controls
	logic          mem_re;
	logic [AW-1:0] mem_ridx;
	logic          mem_we;
	logic [AW-1:0] mem_widx;
	range_t        mem_wdata;
	logic [MA-1:0] mem_raddr;
	logic [MA-1:0] mem_waddr;

	// merge walk
	logic          have_src;
	range_t        src;
	logic          take_new;
	range_t        el;
	logic          join_acc;
	logic          walk_done;
	logic [CW-1:0] idx_nx;
	logic [AW-1:0] m_less;

	// segment check
	logic [31:0] send_c;
	logic        seg_rej;
	logic [31:0] start_c;

	// read
	logic [31:0] size_c;

	logic        slot_free;
	logic        out_load;
	logic        ack_last;
	res_t        base_res;
	res_t        read_res;
	res_t        merge_res;
	res_t        gap_res;

	assign req_stall = (state_q != ST_IDLE);
	assign slot_free = !out_valid_q || !res_stall;
	assign out_load  = slot_free && ((state_q == ST_EMIT) || (state_q == ST_ACK_EM));
	assign idx_nx    = idx_q + CW'(1);
	assign m_less    = AW'(m_q - MW'(1));

	always_comb begin
		base_res = '0;
		base_res.contiguous_end = head_q.e;
		base_res.last = 1'b1;
	end

	always_comb begin
		send_c  = seq_q + 32'(len_q);
		seg_rej = (32'(len_q) > 32'(MAX_SEG_LEN)) || !seq_before(head_q.e, send_c) ||
			!seq_before(send_c, head_q.s + BUF_SIZE);
		start_c = seq_before(head_q.e, seq_q) ? seq_q : head_q.e;
	end

	always_comb begin
		size_c = (diff_q < 32'(rlen_q)) ? diff_q : 32'(rlen_q);
	end

	always_comb begin
		read_res = base_res;
		if (diff_q == '0) begin
			read_res.would_block = 1'b1;
		end else begin
			read_res.accepted   = 1'b1;
			read_res.buffer_pos = 22'(head_q.s & BUF_MASK);
			read_res.byte_count = size_c[22:0];
		end
	end

	always_comb begin
		merge_res = base_res;
		if (m_q > MW'(MAX_RANGES)) begin
			merge_res.list_full = 1'b1;
		end else begin
			merge_res.accepted       = 1'b1;
			merge_res.buffer_pos     = 22'(start_q & BUF_MASK);
			merge_res.data_offset    = 12'(start_q - seq_q);
			merge_res.byte_count     = 23'(send_q - start_q);
			merge_res.contiguous_end = (m_q == MW'(1)) ? acc_q.e : nh_q.e;
		end
	end

	always_comb begin
		gap_res = base_res;
		gap_res.gap_start = prev_e_q;
		gap_res.gap_end   = rd_q.s;
		gap_res.gap_valid = 1'b1;
		gap_res.last      = ack_last;
	end

	// one element of the sorted stream per cycle: the new range goes in front
	// of the first range that does not start before it
	always_comb begin
		have_src  = (idx_q < count_q);
		src       = (idx_q == '0) ? head_q : rd_q;
		take_new  = !ins_q && (!have_src || !seq_before(src.s, start_q));
		el        = take_new ? range_t'{s: start_q, e: send_q} : src;
		join_acc  = (m_q != '0) && !seq_before(acc_q.e, el.s);
		walk_done = (take_new && !have_src) || (!take_new && ins_q && (idx_nx == count_q));
	end

	always_comb begin
		ack_last = (idx_nx == count_q) || (n_q == NW'(MAX_OUT - 1));
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_ridx  = '0;
		mem_we    = 1'b0;
		mem_widx  = m_less;
		mem_wdata = acc_q;
		unique case (state_q)
			ST_MERGE: begin
				if (!take_new && idx_nx < count_q) begin
					mem_re   = 1'b1;
					mem_ridx = AW'(idx_nx);
				end
				if (!join_acc && m_q != '0 && m_less != '0)
					mem_we = 1'b1;
			end
			ST_MFIN: begin
				if (m_q <= MW'(MAX_RANGES) && m_less != '0)
					mem_we = 1'b1;
			end
			ST_ACK_RD: begin
				mem_re   = 1'b1;
				mem_ridx = AW'(idx_q);
			end
			default: ;
		endcase
	end

	assign mem_raddr = MA'(mem_ridx) + (bank_q ? MA'(MAX_RANGES) : MA'(0));
	assign mem_waddr = MA'(mem_widx) + (bank_q ? MA'(0) : MA'(MAX_RANGES));

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= CW'(1);
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!res_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q    <= opcode;
						seq_q   <= seq_start;
						len_q   <= seg_len;
						rlen_q  <= request_len;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					unique case (op_q)
						OP_SEG: begin
							if (seg_rej) begin
								res_q   <= base_res;
								state_q <= ST_EMIT;
							end else begin
								start_q <= start_c;
								send_q  <= send_c;
								idx_q   <= '0;
								m_q     <= '0;
								ins_q   <= 1'b0;
								state_q <= ST_MERGE;
							end
						end
						OP_READ: begin
							diff_q  <= head_q.e - head_q.s;
							state_q <= ST_READ;
						end
						OP_ACK: begin
							prev_e_q <= head_q.e;
							idx_q    <= CW'(1);
							n_q      <= '0;
							if (count_q == CW'(1)) begin
								res_q   <= base_res;
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_ACK_RD;
							end
						end
						default: begin
							res_q   <= base_res;
							state_q <= ST_EMIT;
						end
					endcase
				end
				ST_READ: begin
					res_q <= read_res;
					if (diff_q != '0)
						head_q.s <= head_q.s + size_c;
					state_q <= ST_EMIT;
				end
				ST_MERGE: begin
					if (take_new)
						ins_q <= 1'b1;
					else
						idx_q <= idx_nx;
					if (join_acc) begin
						if (seq_before(acc_q.e, el.e))
							acc_q.e <= el.e;
					end else begin
						if (m_q != '0 && m_less == '0)
							nh_q <= acc_q;
						acc_q <= el;
						m_q   <= m_q + MW'(1);
					end
					if (walk_done)
						state_q <= ST_MFIN;
				end
				ST_MFIN: begin
					res_q <= merge_res;
					if (m_q <= MW'(MAX_RANGES)) begin
						head_q  <= (m_q == MW'(1)) ? acc_q : nh_q;
						count_q <= CW'(m_q);
						bank_q  <= !bank_q;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				ST_ACK_RD: begin
					state_q <= ST_ACK_EM;
				end
				ST_ACK_EM: begin
					if (slot_free) begin
						out_q    <= gap_res;
						prev_e_q <= rd_q.e;
						idx_q    <= idx_nx;
						n_q      <= n_q + NW'(1);
						state_q  <= ack_last ? ST_IDLE : ST_ACK_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid      = out_valid_q;
	assign accepted       = out_q.accepted;
	assign would_block    = out_q.would_block;
	assign list_full      = out_q.list_full;
	assign buffer_pos     = out_q.buffer_pos;
	assign data_offset    = out_q.data_offset;
	assign byte_count     = out_q.byte_count;
	assign contiguous_end = out_q.contiguous_end;
	assign gap_start      = out_q.gap_start;
	assign gap_end        = out_q.gap_end;
	assign gap_valid      = out_q.gap_valid;
	assign last           = out_q.last;

endmodule
`default_nettype wire

>>> dv/reassembly_range_tracker_check.sv
`timescale 1ns / 1ps
module reassembly_range_tracker_check
	import rrt_pkg::*;
#(
	parameter int BUFFER_BYTES = 4194304,
	parameter int MAX_RANGES   = 16,
	parameter int MAX_SEG_LEN  = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] seq_start,
	input  logic [11:0] seg_len,
	input  logic [22:0] request_len,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic        accepted,
	input  logic        would_block,
	input  logic        list_full,
	input  logic [21:0] buffer_pos,
	input  logic [11:0] data_offset,
	input  logic [22:0] byte_count,
	input  logic [31:0] contiguous_end,
	input  logic [31:0] gap_start,
	input  logic [31:0] gap_end,
	input  logic        gap_valid,
	input  logic        last,
	output int          fail_count,
	output int          outstanding,
	output logic [31:0] ack_point,
	output logic [31:0] read_point
);

	logic [31:0] rng_s [MAX_RANGES];
	logic [31:0] rng_e [MAX_RANGES];
	int rng_n;
	res_t range_reports [$];
	int mismatches;

	// serial compare with 32-bit wraparound: a lies before b
	function automatic bit earlier(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic string show(input res_t r);
		return $sformatf({"acc=%0b blk=%0b full=%0b pos=%h off=%0d cnt=%0d ",
			"cend=%h gs=%h ge=%h gv=%0b last=%0b"},
			r.accepted, r.would_block, r.list_full, r.buffer_pos, r.data_offset,
			r.byte_count, r.contiguous_end, r.gap_start, r.gap_end, r.gap_valid, r.last);
	endfunction

	// queue a predicted result at the tail
	function automatic void add_report(input res_t r);
		range_reports.insert(range_reports.size(), r);
	endfunction

	task automatic step_ranges(input logic [1:0] op, input logic [31:0] seq,
			input logic [11:0] len, input logic [22:0] req);
		res_t r;
		logic [31:0] ts [MAX_RANGES + 1];
		logic [31:0] te [MAX_RANGES + 1];
		logic [31:0] ms [MAX_RANGES + 1];
		logic [31:0] me [MAX_RANGES + 1];
		logic [31:0] send, start, avail, grant, pos32, diff;
		int k, m, at;
		if (op == OP_ACK) begin
			for (int i = 1; i < rng_n && i <= MAX_OUT; i++) begin
				r = '0;
				r.contiguous_end = rng_e[0];
				r.gap_start = rng_e[i - 1];
				r.gap_end = rng_s[i];
				r.gap_valid = 1'b1;
				r.last = (i == rng_n - 1) || (i == MAX_OUT);
				add_report(r);
			end
			if (rng_n == 1) begin
				r = '0;
				r.contiguous_end = rng_e[0];
				r.last = 1'b1;
				add_report(r);
			end
		end else begin
			r = '0;
			if (op == OP_SEG) begin
				send = seq + {20'd0, len};
				if (len <= MAX_SEG_LEN && earlier(rng_e[0], send) &&
						earlier(send, rng_s[0] + BUFFER_BYTES)) begin
					start = earlier(rng_e[0], seq) ? seq : rng_e[0];
					// first entry not before the clipped start
					at = rng_n;
					for (int i = rng_n - 1; i >= 0; i--)
						if (!earlier(rng_s[i], start)) at = i;
					k = 0;
					for (int i = 0; i < rng_n; i++) begin
						if (i == at) begin
							ts[k] = start;
							te[k] = send;
							k++;
						end
						ts[k] = rng_s[i];
						te[k] = rng_e[i];
						k++;
					end
					if (at == rng_n) begin
						ts[k] = start;
						te[k] = send;
						k++;
					end
					// merge overlapping or touching neighbours
					m = 0;
					for (int i = 0; i < k; i++) begin
						if (m > 0 && !earlier(me[m - 1], ts[i])) begin
							if (earlier(me[m - 1], te[i])) me[m - 1] = te[i];
						end else begin
							ms[m] = ts[i];
							me[m] = te[i];
							m++;
						end
					end
					if (m > MAX_RANGES) begin
						r.list_full = 1'b1;
					end else begin
						for (int i = 0; i < m; i++) begin
							rng_s[i] = ms[i];
							rng_e[i] = me[i];
						end
						rng_n = m;
						pos32 = start & (BUFFER_BYTES - 1);
						diff = start - seq;
						r.accepted = 1'b1;
						r.buffer_pos = pos32[21:0];
						r.data_offset = diff[11:0];
						diff = send - start;
						r.byte_count = diff[22:0];
					end
				end
			end else if (op == OP_READ) begin
				avail = rng_e[0] - rng_s[0];
				if (avail == 0) begin
					r.would_block = 1'b1;
				end else begin
					grant = (avail < {9'd0, req}) ? avail : {9'd0, req};
					pos32 = rng_s[0] & (BUFFER_BYTES - 1);
					r.accepted = 1'b1;
					r.buffer_pos = pos32[21:0];
					r.byte_count = grant[22:0];
					rng_s[0] = rng_s[0] + grant;
				end
			end
			r.contiguous_end = rng_e[0];
			r.last = 1'b1;
			add_report(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_RANGES; i++) begin
				rng_s[i] = '0;
				rng_e[i] = '0;
			end
			rng_n = 1;
			range_reports.delete();
			mismatches = 0;
		end else begin
			if (res_valid && !res_stall) begin
				got = {accepted, would_block, list_full, buffer_pos, data_offset, byte_count,
					contiguous_end, gap_start, gap_end, gap_valid, last};
				if (range_reports.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: %s", show(got));
					mismatches++;
				end else begin
					want = range_reports.pop_front();
					if (got !== want) begin
						if (mismatches < 10) begin
							$display("mismatch at %0t: want %s", $realtime, show(want));
							$display("                 got  %s", show(got));
						end
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall)
				step_ranges(opcode, seq_start, seg_len, request_len);
		end
		fail_count <= mismatches;
		outstanding <= range_reports.size();
		ack_point <= rng_e[0];
		read_point <= rng_s[0];
	end

endmodule

>>> dv/reassembly_range_tracker_test.sv
`timescale 1ns / 1ps
module reassembly_range_tracker_test
	import rrt_pkg::*;
();

	localparam int BUFFER_BYTES = 4194304;
	localparam int MAX_RANGES   = 16;
	localparam int MAX_SEG_LEN  = 2048;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 374;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] opcode = '0;
	logic [31:0] seq_start = '0;
	logic [11:0] seg_len = '0;
	logic [22:0] request_len = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic accepted, would_block, list_full, gap_valid, last;
	logic [21:0] buffer_pos;
	logic [11:0] data_offset;
	logic [22:0] byte_count;
	logic [31:0] contiguous_end, gap_start, gap_end;

	int fail_count, outstanding;
	logic [31:0] ack_point, read_point;
	int sent_cnt = 0;
	bit held = 1'b0;

	reassembly_range_tracker #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.MAX_RANGES(MAX_RANGES),
		.MAX_SEG_LEN(MAX_SEG_LEN)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.opcode(opcode), .seq_start(seq_start), .seg_len(seg_len), .request_len(request_len),
		.res_valid(res_valid), .res_stall(res_stall),
		.accepted(accepted), .would_block(would_block), .list_full(list_full),
		.buffer_pos(buffer_pos), .data_offset(data_offset), .byte_count(byte_count),
		.contiguous_end(contiguous_end), .gap_start(gap_start), .gap_end(gap_end),
		.gap_valid(gap_valid), .last(last)
	);

	reassembly_range_tracker_check #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.MAX_RANGES(MAX_RANGES),
		.MAX_SEG_LEN(MAX_SEG_LEN)
	) range_check (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.opcode(opcode), .seq_start(seq_start), .seg_len(seg_len), .request_len(request_len),
		.res_valid(res_valid), .res_stall(res_stall),
		.accepted(accepted), .would_block(would_block), .list_full(list_full),
		.buffer_pos(buffer_pos), .data_offset(data_offset), .byte_count(byte_count),
		.contiguous_end(contiguous_end), .gap_start(gap_start), .gap_end(gap_end),
		.gap_valid(gap_valid), .last(last),
		.fail_count(fail_count), .outstanding(outstanding),
		.ack_point(ack_point), .read_point(read_point)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit quiet();
		return sent_cnt >= 260 && sent_cnt < 330;
	endfunction

	// called at a clock edge; returns at the edge where the item is taken
	task automatic offer(input logic [1:0] op, input logic [31:0] seq,
			input logic [11:0] len, input logic [22:0] req);
		while (!quiet() && $urandom_range(0, 99) < 13) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		seq_start <= seq;
		seg_len <= len;
		request_len <= req;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent_cnt++;
	endtask

	// let every result of the items sent so far come out
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// result side: random stall, one long hold-off, a quiet stretch
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sent_cnt >= 150 && !held) begin
				held = 1'b1;
				res_stall <= 1'b1;
				for (k = 0; k < 400; k++) @(posedge clk);
				res_stall <= 1'b0;
			end else if (quiet()) begin
				res_stall <= 1'b0;
			end else begin
				res_stall <= ($urandom_range(0, 99) < 13);
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
				idle = 0;
			else
				idle++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [31:0] ce, rp, sq;
		logic [11:0] ln;
		logic [22:0] rq;
		int pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tracker
		offer(OP_ACK, $urandom, 12'($urandom), 23'($urandom)); settle();
		offer(OP_READ, $urandom, 12'($urandom), 23'd10); settle();
		offer(OP_READ, $urandom, 12'($urandom), 23'd0); settle();
		offer(OP_SPARE, $urandom, 12'($urandom), 23'($urandom)); settle();
		// in order, empty at the ack point, empty beyond it, oversized, old
		offer(OP_SEG, 32'd0, 12'd100, 23'($urandom)); settle();
		offer(OP_SEG, 32'd100, 12'd0, 23'($urandom)); settle();
		offer(OP_SEG, 32'd150, 12'd0, 23'($urandom)); settle();
		offer(OP_SEG, 32'd200, 12'd2049, 23'($urandom)); settle();
		offer(OP_SEG, 32'd300, 12'hfff, 23'($urandom)); settle();
		offer(OP_SEG, 32'd0, 12'd50, 23'($urandom)); settle();
		// partly old, then a segment wrapping from the top of sequence space
		offer(OP_SEG, 32'd50, 12'd100, 23'($urandom)); settle();
		offer(OP_SEG, 32'hffff_ff00, 12'd512, 23'($urandom)); settle();
		// window edge: just inside, then just past
		rp = read_point;
		offer(OP_SEG, rp + BUFFER_BYTES - 20, 12'd19, 23'($urandom)); settle();
		offer(OP_SEG, rp + BUFFER_BYTES - 10, 12'd20, 23'($urandom)); settle();
		offer(OP_READ, $urandom, 12'($urandom), 23'd0); settle();
		offer(OP_READ, $urandom, 12'($urandom), 23'h7fffff); settle();
		offer(OP_READ, $urandom, 12'($urandom), 23'd5); settle();
		// fill the list with gaps until a segment is dropped
		ce = ack_point;
		for (int i = 0; i < 16; i++) begin
			offer(OP_SEG, ce + 200 * i + 100, 12'd40, 23'($urandom));
			settle();
		end
		offer(OP_ACK, $urandom, 12'($urandom), 23'($urandom)); settle();
		offer(OP_SEG, ce, 12'd100, 23'($urandom)); settle();
		offer(OP_ACK, $urandom, 12'($urandom), 23'($urandom)); settle();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			ce = ack_point;
			rp = read_point;
			sq = $urandom;
			ln = 12'($urandom);
			rq = 23'($urandom);
			if (pick < 40) begin
				// next in-order data, often overlapping what is there
				sq = ce - $urandom_range(0, 300);
				ln = 12'($urandom_range(1, 600));
				offer(OP_SEG, sq, ln, rq);
			end else if (pick < 58) begin
				sq = ce + $urandom_range(1, 12000);
				ln = 12'($urandom_range(0, 1500));
				offer(OP_SEG, sq, ln, rq);
			end else if (pick < 63) begin
				if ($urandom_range(0, 1)) begin
					sq = rp + BUFFER_BYTES - $urandom_range(0, 1500);
					ln = 12'($urandom_range(1500, MAX_SEG_LEN));
				end else begin
					sq = ce - $urandom_range(600, 5000);
					ln = 12'($urandom_range(0, 500));
				end
				offer(OP_SEG, sq, ln, rq);
			end else if (pick < 68) begin
				offer(2'($urandom_range(0, 3)), sq, ln, rq);
			end else if (pick < 85) begin
				if ($urandom_range(0, 9) != 0) rq = 23'($urandom_range(0, 3000));
				offer(OP_READ, sq, ln, rq);
			end else if (pick < 95) begin
				offer(OP_ACK, sq, ln, rq);
			end else begin
				offer(OP_SPARE, sq, ln, rq);
			end
		end

		settle();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
